FILE: rtl/stk_calc_pkg.sv
// types, constants and command codes shared by the stack calculator modules
`default_nettype none

package stk_calc_pkg;

  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned DEPTH_W     = 7;
  localparam int unsigned CNT_W       = $clog2(DATA_W);

  typedef enum logic [3:0] {
    CMD_PUSH    = 4'd0,
    CMD_ADD     = 4'd1,
    CMD_SUB     = 4'd2,
    CMD_MUL     = 4'd3,
    CMD_DIV     = 4'd4,
    CMD_DUP     = 4'd5,
    CMD_DROP    = 4'd6,
    CMD_SWAP    = 4'd7,
    CMD_OVER    = 4'd8,
    CMD_PRINT   = 4'd9,
    CMD_NEWLINE = 4'd10,
    CMD_UNKNOWN = 4'd11,
    CMD_EOL     = 4'd12
  } cmd_e;

  typedef enum logic [2:0] {
    EV_SILENT  = 3'd0,
    EV_PRINT   = 3'd1,
    EV_NEWLINE = 3'd2,
    EV_LINE_OK = 3'd3,
    EV_ABORT   = 3'd4
  } event_e;

  typedef enum logic [2:0] {
    FLT_NONE    = 3'd0,
    FLT_FULL    = 3'd1,
    FLT_EMPTY   = 3'd2,
    FLT_DIVZERO = 3'd3,
    FLT_UNKNOWN = 3'd4
  } fault_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_DIV,
    ST_SWAP
  } state_e;

  typedef enum logic [1:0] {
    WA_SP,
    WA_SP_M1,
    WA_SP_M2
  } wr_addr_e;

  typedef enum logic [2:0] {
    WD_LIT,
    WD_TOP,
    WD_NEXT,
    WD_SUM,
    WD_DIFF,
    WD_PROD,
    WD_QUOT
  } wr_data_e;

  typedef enum logic [2:0] {
    SP_HOLD,
    SP_INC,
    SP_DEC1,
    SP_DEC2,
    SP_CLEAR
  } sp_op_e;

  typedef struct packed {
    logic        [3:0]        command;
    logic signed [DATA_W-1:0] literal;
  } in_word_t;

  typedef struct packed {
    logic        [2:0]         event_res;
    logic signed [DATA_W-1:0]  value;
    logic        [2:0]         fault;
    logic        [DEPTH_W-1:0] depth;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic     capture;
    logic     wr_en;
    wr_addr_e wr_addr;
    wr_data_e wr_data;
    sp_op_e   sp_op;
    fault_e   err_set;
    logic     err_clr;
    logic     div_start;
    logic     out_load;
    event_e   out_event;
    logic     out_show_top;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic [3:0] cmd;
    logic       sp_zero;
    logic       sp_one;
    logic       sp_full;
    logic       err_any;
    logic       top_zero;
    logic       div_done;
    logic       out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/stack_calculator_core.sv
// top level of the stack calculator: controller and datapath
//
// Executes pre-decoded Forth-style words against a 64-entry stack of 32-bit
// signed values. Input channel in_valid_i/in_ready_o carries one command word
// (command code and literal); output channel out_valid_o/out_ready_i returns
// exactly one result word per command (event, printed value, line fault,
// stack depth). Both sides transfer when valid and ready are high together.
// Words are processed one at a time. Most commands read memory as the word is
// taken, then execute, the result being loaded into the output register in
// the execute state that follows; multiply and swap go through a further state
// (registered product, second stack write); divide starts the one bit per cycle
// divider and, once its 32 steps are done, writes the quotient back. A result sits in an output register;
// the next word is taken once the block is idle and that register is empty or
// being read in the same cycle, so a stalled receiver holds the result and
// blocks further input.
// After reset the stack is empty and no line error is pending; stack memory
// contents are not cleared, as only entries below the pointer are ever used.
`default_nettype none

module stack_calculator_core (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire stk_calc_pkg::in_word_t  in_word_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output stk_calc_pkg::out_word_t      out_word_o
);

  stk_calc_pkg::ctl_t ctl;
  stk_calc_pkg::sts_t sts;

  stk_calc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  stk_calc_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

FILE: rtl/stk_calc_div.sv
// signed 32-bit divider, truncating toward zero, one quotient bit per cycle
`default_nettype none

module stk_calc_div (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic [stk_calc_pkg::DATA_W-1:0]   dividend_i,
  input  wire logic [stk_calc_pkg::DATA_W-1:0]   divisor_i,
  output logic                                   done_o,
  output logic      [stk_calc_pkg::DATA_W-1:0]   quotient_o
);

  logic                              busy_q;
  logic                              done_q;
  logic [stk_calc_pkg::CNT_W-1:0]    cnt_q;
  logic [stk_calc_pkg::DATA_W-1:0]   rem_q;
  logic [stk_calc_pkg::DATA_W-1:0]   quo_q;
  logic [stk_calc_pkg::DATA_W-1:0]   ub_q;
  logic                              neg_q;

  logic [stk_calc_pkg::DATA_W-1:0]   ua;
  logic [stk_calc_pkg::DATA_W-1:0]   ub;
  logic [stk_calc_pkg::DATA_W:0]     rem_sh;
  logic [stk_calc_pkg::DATA_W:0]     rem_sub;
  logic                              ge;

  assign ua = dividend_i[stk_calc_pkg::DATA_W-1] ?
              (stk_calc_pkg::DATA_W'(0) - dividend_i) : dividend_i;
  assign ub = divisor_i[stk_calc_pkg::DATA_W-1] ?
              (stk_calc_pkg::DATA_W'(0) - divisor_i) : divisor_i;

  assign rem_sh  = {rem_q, quo_q[stk_calc_pkg::DATA_W-1]};
  assign rem_sub = rem_sh - {1'b0, ub_q};
  assign ge      = rem_sh >= {1'b0, ub_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + stk_calc_pkg::CNT_W'(1);
      if (cnt_q == stk_calc_pkg::CNT_W'(stk_calc_pkg::DATA_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= ua;
      ub_q  <= ub;
      neg_q <= dividend_i[stk_calc_pkg::DATA_W-1] ^ divisor_i[stk_calc_pkg::DATA_W-1];
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[stk_calc_pkg::DATA_W-1:0] : rem_sh[stk_calc_pkg::DATA_W-1:0];
      quo_q <= {quo_q[stk_calc_pkg::DATA_W-2:0], ge};
    end
  end

  // most negative over minus one wraps back to the most negative value
  assign quotient_o = neg_q ? (stk_calc_pkg::DATA_W'(0) - quo_q) : quo_q;
  assign done_o     = done_q;

endmodule

`default_nettype wire

FILE: rtl/stk_calc_dpath.sv
// datapath: stack memory, pointer, line error, operand registers, alu and output register
`default_nettype none

module stk_calc_dpath (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire stk_calc_pkg::in_word_t  in_word_i,
  input  wire stk_calc_pkg::ctl_t      ctl_i,
  output stk_calc_pkg::sts_t           sts_o,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output stk_calc_pkg::out_word_t      out_word_o
);

  logic [3:0]                        cmd_q;
  logic [stk_calc_pkg::DATA_W-1:0]   lit_q;
  logic [stk_calc_pkg::DATA_W-1:0]   top_q;
  logic [stk_calc_pkg::DATA_W-1:0]   next_q;
  logic [stk_calc_pkg::DATA_W-1:0]   prod_q;
  logic [stk_calc_pkg::SP_W-1:0]     sp_q, sp_d;
  stk_calc_pkg::fault_e              err_q, err_d;
  logic                              out_valid_q;
  stk_calc_pkg::out_word_t           out_word_q, out_word_d;

  logic [stk_calc_pkg::DATA_W-1:0]   mem [stk_calc_pkg::STACK_DEPTH];

  logic [stk_calc_pkg::ADDR_W-1:0]   addr_sp, addr_m1, addr_m2, wr_addr;
  logic [stk_calc_pkg::DATA_W-1:0]   wr_data;
  logic [stk_calc_pkg::DATA_W-1:0]   quot;
  logic                              div_done;
  stk_calc_pkg::fault_e              fault_now;

  assign addr_sp = stk_calc_pkg::ADDR_W'(sp_q);
  assign addr_m1 = stk_calc_pkg::ADDR_W'(sp_q - stk_calc_pkg::SP_W'(1));
  assign addr_m2 = stk_calc_pkg::ADDR_W'(sp_q - stk_calc_pkg::SP_W'(2));

  stk_calc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctl_i.div_start),
    .dividend_i (next_q),
    .divisor_i  (top_q),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  always_comb begin
    case (ctl_i.wr_addr)
      stk_calc_pkg::WA_SP:    wr_addr = addr_sp;
      stk_calc_pkg::WA_SP_M1: wr_addr = addr_m1;
      stk_calc_pkg::WA_SP_M2: wr_addr = addr_m2;
      default:                wr_addr = addr_sp;
    endcase
  end

  always_comb begin
    case (ctl_i.wr_data)
      stk_calc_pkg::WD_LIT:  wr_data = lit_q;
      stk_calc_pkg::WD_TOP:  wr_data = top_q;
      stk_calc_pkg::WD_NEXT: wr_data = next_q;
      stk_calc_pkg::WD_SUM:  wr_data = next_q + top_q;
      stk_calc_pkg::WD_DIFF: wr_data = next_q - top_q;
      stk_calc_pkg::WD_PROD: wr_data = prod_q;
      stk_calc_pkg::WD_QUOT: wr_data = quot;
      default:               wr_data = lit_q;
    endcase
  end

  // stack memory, operand reads issued as the word is taken
  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      cmd_q  <= in_word_i.command;
      lit_q  <= in_word_i.literal;
      top_q  <= mem[addr_m1];
      next_q <= mem[addr_m2];
    end
    if (ctl_i.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    prod_q <= next_q * top_q;
  end

  always_comb begin
    case (ctl_i.sp_op)
      stk_calc_pkg::SP_HOLD:  sp_d = sp_q;
      stk_calc_pkg::SP_INC:   sp_d = sp_q + stk_calc_pkg::SP_W'(1);
      stk_calc_pkg::SP_DEC1:  sp_d = sp_q - stk_calc_pkg::SP_W'(1);
      stk_calc_pkg::SP_DEC2:  sp_d = sp_q - stk_calc_pkg::SP_W'(2);
      stk_calc_pkg::SP_CLEAR: sp_d = '0;
      default:                sp_d = sp_q;
    endcase
  end

  always_comb begin
    err_d = err_q;
    if (ctl_i.err_clr) begin
      err_d = stk_calc_pkg::FLT_NONE;
    end else if (ctl_i.err_set != stk_calc_pkg::FLT_NONE) begin
      err_d = ctl_i.err_set;
    end
  end

  // at end of line the old error is reported even though it is being cleared
  assign fault_now = (ctl_i.err_set != stk_calc_pkg::FLT_NONE) ? ctl_i.err_set : err_q;

  always_comb begin
    out_word_d.event_res = ctl_i.out_event;
    out_word_d.value     = ctl_i.out_show_top ? top_q : '0;
    out_word_d.fault     = fault_now;
    out_word_d.depth     = stk_calc_pkg::DEPTH_W'(sp_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q        <= '0;
      err_q       <= stk_calc_pkg::FLT_NONE;
      out_valid_q <= 1'b0;
    end else begin
      sp_q  <= sp_d;
      err_q <= err_d;
      if (ctl_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  always_comb begin
    sts_o.cmd      = cmd_q;
    sts_o.sp_zero  = (sp_q == '0);
    sts_o.sp_one   = (sp_q == stk_calc_pkg::SP_W'(1));
    sts_o.sp_full  = (sp_q == stk_calc_pkg::SP_W'(stk_calc_pkg::STACK_DEPTH));
    sts_o.err_any  = (err_q != stk_calc_pkg::FLT_NONE);
    sts_o.top_zero = (top_q == '0);
    sts_o.div_done = div_done;
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= stk_calc_pkg::SP_W'(stk_calc_pkg::STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.wr_en && (ctl_i.wr_addr == stk_calc_pkg::WA_SP) |-> !sts_o.sp_full)
    else $error("push written while stack full");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != stk_calc_pkg::FLT_NONE) && !ctl_i.err_clr |=> err_q == $past(err_q))
    else $error("line error changed before end of line");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a word not yet taken");

endmodule

`default_nettype wire

FILE: rtl/stk_calc_ctrl.sv
// controller: sequences each command word through the datapath
`default_nettype none

module stk_calc_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire stk_calc_pkg::sts_t  sts_i,
  output stk_calc_pkg::ctl_t       ctl_o
);

  stk_calc_pkg::state_e state_q, state_d;
  stk_calc_pkg::sp_op_e pair_fail_op;
  logic                 pair_bad;
  logic                 finish;

  assign in_ready_o   = (state_q == stk_calc_pkg::ST_IDLE) && sts_i.out_free;
  // a two-operand word on a one-entry stack still consumes the top
  assign pair_bad     = sts_i.sp_zero || sts_i.sp_one;
  assign pair_fail_op = sts_i.sp_one ? stk_calc_pkg::SP_DEC1 : stk_calc_pkg::SP_HOLD;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stk_calc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d            = state_q;
    ctl_o              = '0;
    ctl_o.wr_addr      = stk_calc_pkg::WA_SP;
    ctl_o.wr_data      = stk_calc_pkg::WD_LIT;
    ctl_o.sp_op        = stk_calc_pkg::SP_HOLD;
    ctl_o.err_set      = stk_calc_pkg::FLT_NONE;
    ctl_o.out_event    = stk_calc_pkg::EV_SILENT;
    finish             = 1'b0;

    unique case (state_q)
      stk_calc_pkg::ST_IDLE: begin
        ctl_o.capture = in_valid_i && in_ready_o;
        if (ctl_o.capture) begin
          state_d = stk_calc_pkg::ST_EXEC;
        end
      end

      stk_calc_pkg::ST_EXEC: begin
        finish = 1'b1;
        if (sts_i.cmd == stk_calc_pkg::CMD_EOL) begin
          ctl_o.err_clr = 1'b1;
          if (sts_i.err_any) begin
            ctl_o.sp_op     = stk_calc_pkg::SP_CLEAR;
            ctl_o.out_event = stk_calc_pkg::EV_ABORT;
          end else begin
            ctl_o.out_event = stk_calc_pkg::EV_LINE_OK;
          end
        end else if (!sts_i.err_any) begin
          unique case (sts_i.cmd) inside
            stk_calc_pkg::CMD_PUSH: begin
              if (sts_i.sp_full) begin
                ctl_o.err_set = stk_calc_pkg::FLT_FULL;
              end else begin
                ctl_o.wr_en   = 1'b1;
                ctl_o.wr_addr = stk_calc_pkg::WA_SP;
                ctl_o.wr_data = stk_calc_pkg::WD_LIT;
                ctl_o.sp_op   = stk_calc_pkg::SP_INC;
              end
            end
            stk_calc_pkg::CMD_ADD, stk_calc_pkg::CMD_SUB: begin
              if (pair_bad) begin
                ctl_o.err_set = stk_calc_pkg::FLT_EMPTY;
                ctl_o.sp_op   = pair_fail_op;
              end else begin
                ctl_o.wr_en   = 1'b1;
                ctl_o.wr_addr = stk_calc_pkg::WA_SP_M2;
                ctl_o.wr_data = (sts_i.cmd == stk_calc_pkg::CMD_ADD) ?
                                stk_calc_pkg::WD_SUM : stk_calc_pkg::WD_DIFF;
                ctl_o.sp_op   = stk_calc_pkg::SP_DEC1;
              end
            end
            stk_calc_pkg::CMD_MUL: begin
              if (pair_bad) begin
                ctl_o.err_set = stk_calc_pkg::FLT_EMPTY;
                ctl_o.sp_op   = pair_fail_op;
              end else begin
                finish  = 1'b0;
                state_d = stk_calc_pkg::ST_MUL;
              end
            end
            stk_calc_pkg::CMD_DIV: begin
              if (pair_bad) begin
                ctl_o.err_set = stk_calc_pkg::FLT_EMPTY;
                ctl_o.sp_op   = pair_fail_op;
              end else if (sts_i.top_zero) begin
                ctl_o.err_set = stk_calc_pkg::FLT_DIVZERO;
                ctl_o.sp_op   = stk_calc_pkg::SP_DEC2;
              end else begin
                ctl_o.div_start = 1'b1;
                finish          = 1'b0;
                state_d         = stk_calc_pkg::ST_DIV;
              end
            end
            stk_calc_pkg::CMD_DUP: begin
              if (sts_i.sp_zero) begin
                ctl_o.err_set = stk_calc_pkg::FLT_EMPTY;
              end else if (sts_i.sp_full) begin
                ctl_o.err_set = stk_calc_pkg::FLT_FULL;
              end else begin
                ctl_o.wr_en   = 1'b1;
                ctl_o.wr_addr = stk_calc_pkg::WA_SP;
                ctl_o.wr_data = stk_calc_pkg::WD_TOP;
                ctl_o.sp_op   = stk_calc_pkg::SP_INC;
              end
            end
            stk_calc_pkg::CMD_DROP: begin
              if (sts_i.sp_zero) begin
                ctl_o.err_set = stk_calc_pkg::FLT_EMPTY;
              end else begin
                ctl_o.sp_op = stk_calc_pkg::SP_DEC1;
              end
            end
            stk_calc_pkg::CMD_SWAP: begin
              if (pair_bad) begin
                ctl_o.err_set = stk_calc_pkg::FLT_EMPTY;
                ctl_o.sp_op   = pair_fail_op;
              end else begin
                ctl_o.wr_en   = 1'b1;
                ctl_o.wr_addr = stk_calc_pkg::WA_SP_M1;
                ctl_o.wr_data = stk_calc_pkg::WD_NEXT;
                finish        = 1'b0;
                state_d       = stk_calc_pkg::ST_SWAP;
              end
            end
            stk_calc_pkg::CMD_OVER: begin
              if (pair_bad) begin
                ctl_o.err_set = stk_calc_pkg::FLT_EMPTY;
                ctl_o.sp_op   = pair_fail_op;
              end else if (sts_i.sp_full) begin
                ctl_o.err_set = stk_calc_pkg::FLT_FULL;
              end else begin
                ctl_o.wr_en   = 1'b1;
                ctl_o.wr_addr = stk_calc_pkg::WA_SP;
                ctl_o.wr_data = stk_calc_pkg::WD_NEXT;
                ctl_o.sp_op   = stk_calc_pkg::SP_INC;
              end
            end
            stk_calc_pkg::CMD_PRINT: begin
              if (sts_i.sp_zero) begin
                ctl_o.err_set = stk_calc_pkg::FLT_EMPTY;
              end else begin
                ctl_o.sp_op        = stk_calc_pkg::SP_DEC1;
                ctl_o.out_event    = stk_calc_pkg::EV_PRINT;
                ctl_o.out_show_top = 1'b1;
              end
            end
            stk_calc_pkg::CMD_NEWLINE: begin
              ctl_o.out_event = stk_calc_pkg::EV_NEWLINE;
            end
            default: begin
              ctl_o.err_set = stk_calc_pkg::FLT_UNKNOWN;
            end
          endcase
        end
      end

      stk_calc_pkg::ST_MUL: begin
        ctl_o.wr_en   = 1'b1;
        ctl_o.wr_addr = stk_calc_pkg::WA_SP_M2;
        ctl_o.wr_data = stk_calc_pkg::WD_PROD;
        ctl_o.sp_op   = stk_calc_pkg::SP_DEC1;
        finish        = 1'b1;
      end

      stk_calc_pkg::ST_DIV: begin
        if (sts_i.div_done) begin
          ctl_o.wr_en   = 1'b1;
          ctl_o.wr_addr = stk_calc_pkg::WA_SP_M2;
          ctl_o.wr_data = stk_calc_pkg::WD_QUOT;
          ctl_o.sp_op   = stk_calc_pkg::SP_DEC1;
          finish        = 1'b1;
        end
      end

      stk_calc_pkg::ST_SWAP: begin
        ctl_o.wr_en   = 1'b1;
        ctl_o.wr_addr = stk_calc_pkg::WA_SP_M2;
        ctl_o.wr_data = stk_calc_pkg::WD_TOP;
        finish        = 1'b1;
      end

      default: begin
        state_d = stk_calc_pkg::ST_IDLE;
      end
    endcase

    if (finish) begin
      ctl_o.out_load = 1'b1;
      state_d        = stk_calc_pkg::ST_IDLE;
    end
  end

endmodule

`default_nettype wire

FILE: tb/stack_calculator_core_tb.sv
// self-checking testbench of the stack calculator core with its own stack predictor
`default_nettype none

module stack_calculator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stk_calc_pkg::*;

  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned RESET_CYCLES   = 6;
  localparam int unsigned RANDOM_WORDS   = 1000;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned TAIL_CYCLES    = 60;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned MAX_REPORTS    = 50;

  class calc_scoreboard;
    logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
    int unsigned       stack_ptr;
    fault_e            line_fault;
    out_word_t         pending_results [$];
    int unsigned       mismatches;
    int unsigned       result_count;

    function new();
      stack_ptr    = 0;
      line_fault   = FLT_NONE;
      mismatches   = 0;
      result_count = 0;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function void raise_fault(fault_e f);
      if (line_fault == FLT_NONE) line_fault = f;
    endfunction

    function void push_val(logic [DATA_W-1:0] v);
      if (stack_ptr >= STACK_DEPTH) begin
        raise_fault(FLT_FULL);
      end else begin
        stack_mem[stack_ptr] = v;
        stack_ptr++;
      end
    endfunction

    function bit pop_val(output logic [DATA_W-1:0] v);
      v = '0;
      if (stack_ptr == 0) begin
        raise_fault(FLT_EMPTY);
        return 1'b0;
      end
      stack_ptr--;
      v = stack_mem[stack_ptr];
      return 1'b1;
    endfunction

    // top comes off first, so b is the right-hand operand
    function bit pop_two(output logic [DATA_W-1:0] a, output logic [DATA_W-1:0] b);
      a = '0;
      if (!pop_val(b)) return 1'b0;
      return pop_val(a);
    endfunction

    function logic [DATA_W-1:0] div_trunc(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
      logic [DATA_W-1:0] ua, ub, q;
      ua = a[DATA_W-1] ? -a : a;
      ub = b[DATA_W-1] ? -b : b;
      q  = ua / ub;
      return (a[DATA_W-1] != b[DATA_W-1]) ? -q : q;
    endfunction

    function out_word_t execute_word(in_word_t w);
      logic [DATA_W-1:0] a, b;
      out_word_t         r;
      r = '0;
      a = '0;
      b = '0;
      if (w.command == CMD_EOL) begin
        if (line_fault != FLT_NONE) begin
          stack_ptr   = 0;
          r.event_res = EV_ABORT;
        end else begin
          r.event_res = EV_LINE_OK;
        end
        r.fault    = line_fault;
        line_fault = FLT_NONE;
      end else begin
        // once a line has failed every word up to end of line is skipped
        if (line_fault == FLT_NONE) begin
          case (w.command)
            CMD_PUSH: push_val(w.literal);
            CMD_ADD:  if (pop_two(a, b)) push_val(a + b);
            CMD_SUB:  if (pop_two(a, b)) push_val(a - b);
            CMD_MUL:  if (pop_two(a, b)) push_val(a * b);
            CMD_DIV: begin
              if (pop_two(a, b)) begin
                if (b == '0) raise_fault(FLT_DIVZERO);
                else push_val(div_trunc(a, b));
              end
            end
            CMD_DUP: begin
              if (pop_val(a)) begin
                push_val(a);
                push_val(a);
              end
            end
            CMD_DROP: void'(pop_val(a));
            CMD_SWAP: begin
              if (pop_two(a, b)) begin
                push_val(b);
                push_val(a);
              end
            end
            CMD_OVER: begin
              if (pop_two(a, b)) begin
                push_val(a);
                push_val(b);
                push_val(a);
              end
            end
            CMD_PRINT: begin
              if (pop_val(a)) begin
                r.event_res = EV_PRINT;
                r.value     = a;
              end
            end
            CMD_NEWLINE: r.event_res = EV_NEWLINE;
            default: raise_fault(FLT_UNKNOWN);
          endcase
        end
        r.fault = line_fault;
      end
      r.depth = DEPTH_W'(stack_ptr);
      return r;
    endfunction

    function void note_word(in_word_t w);
      pending_results.push_back(execute_word(w));
    endfunction

    task report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
      if (mismatches < MAX_REPORTS)
        $display("%0t: result %0d, %s: got %0h, expected %0h",
                 $time, result_count, what, got, want);
      mismatches++;
    endtask

    task check_word(out_word_t got);
      out_word_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("word with nothing outstanding", got.value, '0);
      end else begin
        want = pending_results.pop_front();
        if (got.event_res !== want.event_res)
          report_mismatch("event", DATA_W'(got.event_res), DATA_W'(want.event_res));
        if (got.value !== want.value) report_mismatch("value", got.value, want.value);
        if (got.fault !== want.fault)
          report_mismatch("fault", DATA_W'(got.fault), DATA_W'(want.fault));
        if (got.depth !== want.depth)
          report_mismatch("depth", DATA_W'(got.depth), DATA_W'(want.depth));
      end
      result_count++;
    endtask
  endclass

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_word_t  in_word_i   = '0;
  logic      out_ready_i = 1'b0;
  logic      in_ready_o;
  logic      out_valid_o;
  out_word_t out_word_o;

  calc_scoreboard sb = new();
  int unsigned    burst_left = 0;
  int unsigned    words_sent = 0;

  stack_calculator_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_word(out_word_o);
      if (in_valid_i && in_ready_o) sb.note_word(in_word_i);
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  // receiver: free-running, random, fixed on/off pattern and long hold-offs
  initial begin : receiver
    int unsigned phase, mode, len, on_len, off_len;
    phase = 0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      mode = (phase == 8 || $urandom_range(0, 19) == 0) ? 3 : $urandom_range(0, 2);
      len  = $urandom_range(10, 80);
      case (mode)
        0: begin
          repeat (len) begin
            out_ready_i <= 1'b1;
            @(posedge clk_i);
          end
        end
        1: begin
          repeat (len) begin
            out_ready_i <= 1'($urandom_range(0, 1));
            @(posedge clk_i);
          end
        end
        2: begin
          on_len  = $urandom_range(1, 4);
          off_len = $urandom_range(1, 6);
          repeat (len / 4 + 1) begin
            repeat (on_len) begin
              out_ready_i <= 1'b1;
              @(posedge clk_i);
            end
            repeat (off_len) begin
              out_ready_i <= 1'b0;
              @(posedge clk_i);
            end
          end
        end
        default: begin
          repeat (LONG_HOLD) begin
            out_ready_i <= 1'b0;
            @(posedge clk_i);
          end
        end
      endcase
      phase++;
    end
  end

  function automatic logic [DATA_W-1:0] pick_literal();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000;
      3:       return 32'h7fff_ffff;
      4:       return 32'd1;
      5, 6:    return DATA_W'($signed($urandom_range(0, 40)) - 20);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [3:0] pick_command();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return CMD_PUSH;
    if (r < 38) return CMD_ADD;
    if (r < 44) return CMD_SUB;
    if (r < 50) return CMD_MUL;
    if (r < 56) return CMD_DIV;
    if (r < 64) return CMD_DUP;
    if (r < 70) return CMD_DROP;
    if (r < 77) return CMD_SWAP;
    if (r < 84) return CMD_OVER;
    if (r < 94) return CMD_PRINT;
    if (r < 97) return CMD_NEWLINE;
    return CMD_UNKNOWN;
  endfunction

  // sender works in bursts; valid drops in the gap between two bursts and while results are drained
  task automatic offer(logic [3:0] cmd, logic [DATA_W-1:0] lit);
    in_word_t w;
    w.command = cmd;
    w.literal = lit;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
  endtask

  // the first wait lets the monitor note the word taken at this edge
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (sb.pending() != 0);
    @(posedge clk_i);
  endtask

  task automatic random_line();
    int unsigned kind, n;
    kind = $urandom_range(0, 24);
    if (kind == 0) begin
      // abort first so the stack starts empty, then fill to around the top
      offer(CMD_UNKNOWN, $urandom());
      offer(CMD_EOL, $urandom());
      n = $urandom_range(58, 66);
      repeat (n) offer(CMD_PUSH, pick_literal());
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 5))
          0: offer(CMD_DUP, $urandom());
          1: offer(CMD_OVER, $urandom());
          2: offer(CMD_SWAP, $urandom());
          3: offer(CMD_PUSH, pick_literal());
          4: offer(CMD_PRINT, $urandom());
          default: offer(CMD_ADD, $urandom());
        endcase
      end
    end else if (kind < 3) begin
      repeat ($urandom_range(1, 8)) offer(4'($urandom_range(0, 15)), $urandom());
    end else begin
      repeat ($urandom_range(1, 10)) offer(pick_command(), pick_literal());
    end
    offer(CMD_EOL, $urandom());
  endtask

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // print on an empty stack
    offer(CMD_PRINT, 32'hffff_ffff);
    offer(CMD_EOL, 32'h0);
    // wrapping add, most negative over minus one, print of zero
    offer(CMD_PUSH, 32'h7fff_ffff);
    offer(CMD_PUSH, 32'd1);
    offer(CMD_ADD, 32'h0);
    offer(CMD_DUP, 32'h0);
    offer(CMD_PUSH, 32'hffff_ffff);
    offer(CMD_DIV, 32'h0);
    offer(CMD_SUB, 32'h0);
    offer(CMD_PRINT, 32'h0);
    offer(CMD_NEWLINE, 32'h0);
    offer(CMD_EOL, 32'h0);
    // operand order for over, swap and truncating divide
    offer(CMD_PUSH, 32'hffff_fff9);
    offer(CMD_PUSH, 32'd2);
    offer(CMD_OVER, 32'h0);
    offer(CMD_SWAP, 32'h0);
    offer(CMD_DIV, 32'h0);
    offer(CMD_MUL, 32'h0);
    offer(CMD_DUP, 32'h0);
    offer(CMD_DROP, 32'h0);
    offer(CMD_PRINT, 32'h0);
    offer(CMD_EOL, 32'h0);
    // divide by zero, then a skipped word
    offer(CMD_PUSH, 32'd5);
    offer(CMD_PUSH, 32'h0);
    offer(CMD_DIV, 32'h0);
    offer(CMD_PUSH, 32'd1);
    offer(CMD_EOL, 32'h0);
    // undefined code acts as an unknown word
    offer(4'hf, 32'hffff_ffff);
    offer(CMD_EOL, 32'h0);
    drain_results();

    n_loop: while (words_sent < RANDOM_WORDS + 30) begin
      random_line();
      if ($urandom_range(0, 39) == 0) drain_results();
    end

    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (sb.pending() != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
